// File: rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg: shared types and codes of the stop-and-wait sender
// Transaction layouts, configuration register set and the field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

    // configuration port geometry
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RELIABLE_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_PORT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS  = 2'd3;

    // register reset values
    localparam logic        RESET_RELIABLE_MODE = 1'b1;
    localparam logic [15:0] RESET_LOCAL_PORT    = 16'd0;
    localparam logic [23:0] RESET_TIMEOUT_TICKS = 24'd1000;
    localparam logic [7:0]  RESET_MAX_ATTEMPTS  = 8'd3;

    // event codes
    localparam logic [1:0] MODE_SEND    = 2'd0;
    localparam logic [1:0] MODE_SEGMENT = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_LINK    = 2'd3;

    // result kinds
    localparam logic KIND_TRANSMIT = 1'b0;
    localparam logic KIND_DONE     = 1'b1;

    // job status codes
    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_RETRIES   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_LINK_FAIL = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seq_number;
        logic [15:0] payload_len;
        logic [15:0] seg_dest_port;
        logic        seg_is_ack;
        logic [31:0] seg_ack_number;
        logic        seg_well_formed;
        logic        link_ok;
    } sws_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] out_seq;
        logic [7:0]  attempt_number;
        logic [1:0]  status;
    } sws_out_t;

    typedef struct packed {
        logic        reliable_mode;
        logic [15:0] local_port;
        logic [23:0] timeout_ticks;
        logic [7:0]  max_attempts;
    } sws_cfg_t;

endpackage

`default_nettype wire

// File: rtl/sws_core.sv
// ----------------------------------------------------------------------------
// sws_core: event processor of the stop-and-wait sender
// Holds job state and turns one event per go cycle into zero or one result.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_core
    import sws_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     go,
    input  wire sws_in_t  item,
    input  wire sws_cfg_t cfg,
    output logic          res_valid,
    output sws_out_t      res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LINK = 2'd1;
    localparam logic [1:0] PH_ACK  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  attempt_reg, attempt_next;
    logic [23:0] timer_reg, timer_next;

    logic        do_retry;
    logic        do_finish;
    logic [1:0]  fin_status;
    logic        give_up;

    assign give_up = (attempt_reg >= cfg.max_attempts) || (attempt_reg == 8'hFF);

    always_comb
    begin
        phase_next   = phase_reg;
        seq_next     = seq_reg;
        attempt_next = attempt_reg;
        timer_next   = timer_reg;
        do_retry     = 1'b0;
        do_finish    = 1'b0;
        fin_status   = ST_SUCCESS;
        res_valid    = 1'b0;
        res.kind           = KIND_TRANSMIT;
        res.out_seq        = seq_reg;
        res.attempt_number = attempt_reg;
        res.status         = ST_SUCCESS;

        case (item.mode)
            MODE_SEND:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    res_valid   = 1'b1;
                    res.out_seq = item.seq_number;
                    if (item.payload_len > 16'(MAX_PAYLOAD))
                    begin
                        // reject at once, job state untouched
                        res.kind           = KIND_DONE;
                        res.attempt_number = 8'd0;
                        res.status         = ST_TOO_LARGE;
                    end
                    else
                    begin
                        seq_next           = item.seq_number;
                        attempt_next       = 8'd1;
                        phase_next         = PH_LINK;
                        res.attempt_number = 8'd1;
                    end
                end
            end
            MODE_SEGMENT:
            begin
                if (phase_reg == PH_ACK)
                begin
                    if (!item.seg_well_formed || item.seg_dest_port != cfg.local_port)
                        do_retry = 1'b1;
                    else if (item.seg_is_ack && item.seg_ack_number == seq_reg)
                        do_finish = 1'b1;
                end
            end
            MODE_TICK:
            begin
                if (phase_reg == PH_ACK)
                begin
                    if (timer_reg <= 24'd1)
                    begin
                        timer_next = 24'd0;
                        do_retry   = 1'b1;
                    end
                    else
                        timer_next = timer_reg - 24'd1;
                end
            end
            MODE_LINK:
            begin
                if (phase_reg == PH_LINK)
                begin
                    if (!cfg.reliable_mode)
                    begin
                        do_finish  = 1'b1;
                        fin_status = item.link_ok ? ST_SUCCESS : ST_LINK_FAIL;
                    end
                    else if (!item.link_ok)
                        do_retry = 1'b1;
                    else
                    begin
                        timer_next = cfg.timeout_ticks;
                        if (cfg.timeout_ticks == 24'd0)
                            do_retry = 1'b1;
                        else
                            phase_next = PH_ACK;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (do_finish)
        begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = KIND_DONE;
            res.status = fin_status;
        end

        if (do_retry)
        begin
            res_valid = 1'b1;
            if (give_up)
            begin
                phase_next = PH_IDLE;
                res.kind   = KIND_DONE;
                res.status = ST_RETRIES;
            end
            else
            begin
                attempt_next       = attempt_reg + 8'd1;
                phase_next         = PH_LINK;
                res.attempt_number = attempt_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            seq_reg     <= '0;
            attempt_reg <= '0;
            timer_reg   <= '0;
        end
        else if (go)
        begin
            phase_reg   <= phase_next;
            seq_reg     <= seq_next;
            attempt_reg <= attempt_next;
            timer_reg   <= timer_next;
        end
    end

    // a transmit request always carries a live attempt and no error
    a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_TRANSMIT) |->
            (res.status == ST_SUCCESS && res.attempt_number != 8'd0))
        else $error("transmit request with bad attempt or status");

    // every transmit leaves the core waiting for a link report
    a_tx_to_link: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res_valid && res.kind == KIND_TRANSMIT) |=> (phase_reg == PH_LINK))
        else $error("transmit issued without entering link wait");

    // a finished job leaves the core idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res_valid && res.kind == KIND_DONE) |=> (phase_reg == PH_IDLE))
        else $error("job finished but core still busy");

    // a busy core always has at least one attempt on record
    a_busy_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (attempt_reg != 8'd0))
        else $error("busy with zero attempt count");

endmodule

`default_nettype wire

// File: rtl/stop_and_wait_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_sender: control core of a stop-and-wait ARQ sender
//
// Events arrive on the in channel (valid/ready, payload in_data): a send
// request, an arrived segment, a timer tick or a link report. Each event
// yields zero or one result on the out channel (valid/ready, payload
// out_data): a transmit request or a job-finished notice with its status.
// Configuration registers are written through cfg_write_en/cfg_index/
// cfg_data, with no wait; write them only while the core is idle.
//
// An accepted event waits in the event register until the output slot is
// free or draining; then the core processes it and registers any result.
// Throughput without stalls: one event per cycle, set by the single event
// register ahead of the state update, the single result register behind it.
// Reset clears the job state to idle, drops both registers and loads the
// configuration defaults. When the receiver stalls, the result is held in
// the output register; one more event may be buffered in the input
// register, after which in_ready drops until out_ready frees the output.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_sender
    import sws_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sws_in_t                in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sws_out_t                    out_data,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    sws_in_t  in_item_reg;
    logic     in_vld_reg;
    sws_out_t out_item_reg;
    logic     out_vld_reg;
    sws_cfg_t cfg_reg;

    logic     stage_go;
    logic     res_valid;
    sws_out_t res;

    // process the held event when the output slot is free or draining
    assign stage_go = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (stage_go && res_valid)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && res_valid)
            out_item_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reliable_mode <= RESET_RELIABLE_MODE;
            cfg_reg.local_port    <= RESET_LOCAL_PORT;
            cfg_reg.timeout_ticks <= RESET_TIMEOUT_TICKS;
            cfg_reg.max_attempts  <= RESET_MAX_ATTEMPTS;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_RELIABLE_MODE: cfg_reg.reliable_mode <= cfg_data[0];
                REG_LOCAL_PORT:    cfg_reg.local_port    <= cfg_data[15:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[23:0];
                REG_MAX_ATTEMPTS:  cfg_reg.max_attempts  <= cfg_data[7:0];
                default:           cfg_reg.reliable_mode <= cfg_reg.reliable_mode;
            endcase
        end
    end

    sws_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (stage_go),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    // backpressure only while an event is buffered and cannot move on
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && out_vld_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // a stalled result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ready) |-> !stage_go)
        else $error("event processed while result stalled");

    // an accepted event is processed no later than when the output frees
    a_event_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |-> stage_go)
        else $error("held event not processed with free output");

endmodule

`default_nettype wire

// File: test/stop_and_wait_sender_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_sender_test: self-checking bench for the stop-and-wait sender
// A scoreboard tracks the job state and the settings, and predicts the
// transmit requests and job results for every accepted event. Directed
// events cover oversize requests, retries and stray events. Random
// events then follow the job state, with noise mixed in, over several
// register settings. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------

module stop_and_wait_sender_test;
    import sws_pkg::*;

    localparam int unsigned MAX_PAYLOAD   = 1024;
    localparam int unsigned HANG_LIMIT    = 4000;
    localparam int unsigned EVENTS_PER_SET = 100;

    typedef enum logic [1:0] {JOB_IDLE, JOB_WAIT_LINK, JOB_WAIT_ACK} job_phase_t;

    class sender_scoreboard;
        sws_cfg_t    cfg;
        job_phase_t  phase;
        logic [31:0] seq;
        logic [7:0]  attempts;
        logic [23:0] ticks_left;
        sws_out_t    expected_q[$];
        int unsigned mismatches;

        function new();
            cfg.reliable_mode = RESET_RELIABLE_MODE;
            cfg.local_port    = RESET_LOCAL_PORT;
            cfg.timeout_ticks = RESET_TIMEOUT_TICKS;
            cfg.max_attempts  = RESET_MAX_ATTEMPTS;
            phase      = JOB_IDLE;
            seq        = '0;
            attempts   = '0;
            ticks_left = '0;
            mismatches = 0;
        endfunction

        function void push(logic kind, logic [31:0] s, logic [7:0] att, logic [1:0] st);
            sws_out_t r;
            r.kind           = kind;
            r.out_seq        = s;
            r.attempt_number = att;
            r.status         = st;
            expected_q.push_back(r);
        endfunction

        function void close_job(logic [1:0] st);
            phase = JOB_IDLE;
            push(KIND_DONE, seq, attempts, st);
        endfunction

        // failed attempt: send again or give up
        function void retry_or_give_up();
            if (attempts >= cfg.max_attempts || attempts == 8'd255) begin
                close_job(ST_RETRIES);
            end
            else begin
                attempts = attempts + 8'd1;
                phase    = JOB_WAIT_LINK;
                push(KIND_TRANSMIT, seq, attempts, ST_SUCCESS);
            end
        endfunction

        // returns 1 when the event changes the state or gives a result
        function bit note_event(sws_in_t ev);
            case (ev.mode)
                MODE_SEND:
                begin
                    if (phase != JOB_IDLE)
                        return 1'b0;
                    if (ev.payload_len > MAX_PAYLOAD) begin
                        push(KIND_DONE, ev.seq_number, 8'd0, ST_TOO_LARGE);
                        return 1'b1;
                    end
                    seq      = ev.seq_number;
                    attempts = 8'd1;
                    phase    = JOB_WAIT_LINK;
                    push(KIND_TRANSMIT, seq, attempts, ST_SUCCESS);
                    return 1'b1;
                end
                MODE_SEGMENT:
                begin
                    if (phase != JOB_WAIT_ACK)
                        return 1'b0;
                    if (!ev.seg_well_formed || ev.seg_dest_port != cfg.local_port) begin
                        retry_or_give_up();
                        return 1'b1;
                    end
                    if (ev.seg_is_ack && ev.seg_ack_number == seq) begin
                        close_job(ST_SUCCESS);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                MODE_TICK:
                begin
                    if (phase != JOB_WAIT_ACK)
                        return 1'b0;
                    if (ticks_left <= 24'd1) begin
                        ticks_left = '0;
                        retry_or_give_up();
                    end
                    else begin
                        ticks_left = ticks_left - 24'd1;
                    end
                    return 1'b1;
                end
                default:
                begin
                    if (phase != JOB_WAIT_LINK)
                        return 1'b0;
                    if (!cfg.reliable_mode)
                        close_job(ev.link_ok ? ST_SUCCESS : ST_LINK_FAIL);
                    else if (!ev.link_ok)
                        retry_or_give_up();
                    else begin
                        ticks_left = cfg.timeout_ticks;
                        if (ticks_left == '0)
                            retry_or_give_up();
                        else
                            phase = JOB_WAIT_ACK;
                    end
                    return 1'b1;
                end
            endcase
        endfunction

        function void check_result(sws_out_t got);
            sws_out_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d seq %0h attempt %0d status %0d",
                       got.kind, got.out_seq, got.attempt_number, got.status);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.out_seq !== want.out_seq) begin
                $error("out_seq: expected %0h, got %0h", want.out_seq, got.out_seq);
                mismatches++;
            end
            if (got.attempt_number !== want.attempt_number) begin
                $error("attempt_number: expected %0d, got %0d",
                       want.attempt_number, got.attempt_number);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    sws_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    sws_out_t               out_data;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sender_scoreboard board;
    bit               no_gaps;
    int unsigned      stall_left = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      effective_count;

    stop_and_wait_sender #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sws_in_t random_event(logic [1:0] mode);
        sws_in_t ev;
        ev.mode            = mode;
        ev.seq_number      = $urandom;
        ev.payload_len     = 16'($urandom_range(0, 16'hFFFF));
        ev.seg_dest_port   = 16'($urandom_range(0, 16'hFFFF));
        ev.seg_is_ack      = 1'($urandom_range(0, 1));
        ev.seg_ack_number  = $urandom;
        ev.seg_well_formed = 1'($urandom_range(0, 1));
        ev.link_ok         = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // mostly events that move the current job along, some noise
    function automatic sws_in_t pick_event();
        sws_in_t     ev;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return random_event(2'($urandom_range(0, 3)));
        r = $urandom_range(0, 99);
        case (board.phase)
            JOB_IDLE:
            begin
                ev = random_event(MODE_SEND);
                if (r < 80)
                    ev.payload_len = 16'($urandom_range(0, MAX_PAYLOAD));
            end
            JOB_WAIT_LINK:
            begin
                ev = random_event(MODE_LINK);
                ev.link_ok = (r < 85);
            end
            default:
            begin
                if (r < 40) begin
                    ev = random_event(MODE_TICK);
                end
                else begin
                    ev = random_event(MODE_SEGMENT);
                    ev.seg_dest_port   = board.cfg.local_port;
                    ev.seg_well_formed = 1'b1;
                    ev.seg_is_ack      = 1'b1;
                    ev.seg_ack_number  = board.seq;
                    if (r >= 90)
                        ev.seg_well_formed = 1'b0;
                    else if (r >= 80)
                        ev.seg_dest_port = board.cfg.local_port ^
                                           16'($urandom_range(1, 16'hFFFF));
                    else if (r >= 70)
                        ev.seg_ack_number = board.seq + $urandom_range(1, 32'hFFFF_FFFE);
                    else if (r >= 60)
                        ev.seg_is_ack = 1'b0;
                end
            end
        endcase
        return ev;
    endfunction

    function automatic sws_cfg_t make_config(logic rel, logic [15:0] port,
                                             logic [23:0] tmo, logic [7:0] att);
        sws_cfg_t c;
        c.reliable_mode = rel;
        c.local_port    = port;
        c.timeout_ticks = tmo;
        c.max_attempts  = att;
        return c;
    endfunction

    // hold the event until accepted, then idle for a random gap
    task automatic send_event(input sws_in_t ev);
        int unsigned gap;
        in_data  <= ev;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (board.note_event(ev))
            effective_count++;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_request(input logic [31:0] s, input logic [15:0] len);
        sws_in_t ev;
        ev = random_event(MODE_SEND);
        ev.seq_number  = s;
        ev.payload_len = len;
        send_event(ev);
    endtask

    task automatic send_link(input logic ok);
        sws_in_t ev;
        ev = random_event(MODE_LINK);
        ev.link_ok = ok;
        send_event(ev);
    endtask

    task automatic send_arrival(input logic [15:0] port, input logic ack,
                                input logic [31:0] ackno, input logic formed);
        sws_in_t ev;
        ev = random_event(MODE_SEGMENT);
        ev.seg_dest_port   = port;
        ev.seg_is_ack      = ack;
        ev.seg_ack_number  = ackno;
        ev.seg_well_formed = formed;
        send_event(ev);
    endtask

    // drop valid and hold until every expected result is back
    task automatic await_results(input int unsigned extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (board.expected_q.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // end any open job with failures so the core goes idle
    task automatic close_open_job();
        while (board.phase != JOB_IDLE) begin
            if (board.phase == JOB_WAIT_LINK)
                send_link(1'b0);
            else
                send_arrival(board.cfg.local_port, 1'b1, board.seq, 1'b0);
        end
        await_results(4);
    endtask

    task automatic load_config(input sws_cfg_t c);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_RELIABLE_MODE;
        cfg_data     <= CFG_DATA_W'(c.reliable_mode);
        @(posedge clk);
        cfg_index    <= REG_LOCAL_PORT;
        cfg_data     <= CFG_DATA_W'(c.local_port);
        @(posedge clk);
        cfg_index    <= REG_TIMEOUT_TICKS;
        cfg_data     <= c.timeout_ticks;
        @(posedge clk);
        cfg_index    <= REG_MAX_ATTEMPTS;
        cfg_data     <= CFG_DATA_W'(c.max_attempts);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        board.cfg = c;
        @(posedge clk);
    endtask

    // result side: check, then stall at random
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        sws_cfg_t    settings[6];
        int unsigned start_count;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_data        <= '0;
        cfg_write_en   <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        effective_count = 0;
        no_gaps         = 1'b0;
        board           = new();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: reliable, port 0, long timeout, three attempts
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'h0000_0001, 16'(MAX_PAYLOAD + 1));
        send_request(32'h0000_0000, 16'(MAX_PAYLOAD));
        send_request(32'hDEAD_BEEF, 16'd10);               // busy: dropped
        send_event(random_event(MODE_TICK));               // stray tick
        send_arrival(16'd0, 1'b1, 32'h0, 1'b1);            // stray segment
        send_link(1'b1);
        send_link(1'b1);                                   // stray link report
        send_arrival(16'd0, 1'b0, 32'h0, 1'b1);            // not an ACK
        send_arrival(16'd0, 1'b1, 32'h5, 1'b1);            // wrong ACK number
        send_arrival(16'hFFFF, 1'b1, 32'h0, 1'b1);         // wrong port
        send_link(1'b0);
        send_link(1'b1);
        send_arrival(16'd0, 1'b1, 32'h0, 1'b0);            // malformed: give up
        send_request(32'h1234_5678, 16'd0);
        send_link(1'b1);
        send_event(random_event(MODE_TICK));
        send_arrival(16'd0, 1'b1, 32'h1234_5678, 1'b1);
        await_results(4);

        settings[0] = make_config(1'b1, 16'($urandom), 24'($urandom_range(1, 6)),
                                  8'($urandom_range(1, 5)));
        settings[1] = make_config(1'b0, 16'($urandom), 24'd3, 8'd2);
        settings[2] = make_config(1'b1, 16'hFFFF, 24'hFF_FFFF, 8'd255);
        settings[3] = make_config(1'b1, 16'd0, 24'd1, 8'd255);
        settings[4] = make_config(1'b1, 16'($urandom), 24'd0, 8'd0);
        settings[5] = make_config(1'b1, 16'($urandom), 24'd2, 8'd1);

        foreach (settings[i]) begin
            load_config(settings[i]);
            no_gaps = (i == 1 || i == 5);
            if (i == 1) begin
                // send once: link failure and link success
                send_request(32'hCAFE_0001, 16'd64);
                send_link(1'b0);
                send_request(32'hCAFE_0002, 16'd64);
                send_link(1'b1);
            end
            start_count = effective_count;
            while (effective_count - start_count < EVENTS_PER_SET) begin
                send_event(pick_event());
                if ($urandom_range(0, 79) == 0)
                    await_results(0);
            end
            close_open_job();
        end

        no_gaps = 1'b0;
        await_results(10);
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
rtl/sws_pkg.sv
rtl/sws_core.sv
rtl/stop_and_wait_sender.sv
test/stop_and_wait_sender_test.sv
